FILE: design/acts_pkg.sv
// Shared types, widths and codes of the autocorrelation thinning statistics unit.
`timescale 1ns / 1ps

package acts_pkg;

  localparam int MaxSamples = 4096;
  localparam int AddrW      = 12;
  localparam int CntW       = 13;
  localparam int SampleW    = 32;
  localparam int ProdW      = 2 * SampleW;
  localparam int PaW        = ProdW + CntW + 3;
  localparam int SumW       = SampleW + CntW + 3;
  localparam int WideW      = 128;
  localparam int DivW       = WideW + 8;
  localparam int QuoW       = 64;
  localparam int TauW       = 48;
  localparam int FactW      = 8;
  localparam int FprodW     = TauW + FactW;
  localparam int StepW      = 7;
  localparam int IdxW       = 2;

  typedef logic signed [SampleW-1:0] smp_t;
  typedef logic signed [ProdW-1:0]   prod_t;
  typedef logic signed [PaW-1:0]     pa_t;
  typedef logic signed [SumW-1:0]    sum_t;
  typedef logic signed [WideW-1:0]   wide_t;
  typedef logic        [WideW-1:0]   uwide_t;
  typedef logic        [DivW-1:0]    dwide_t;
  typedef logic        [QuoW-1:0]    quo_t;
  typedef logic        [CntW-1:0]    cnt_t;
  typedef logic        [AddrW-1:0]   addr_t;
  typedef logic        [TauW-1:0]    tau_t;
  typedef logic        [FactW-1:0]   fact_t;
  typedef logic        [FprodW-1:0]  fprod_t;
  typedef logic        [StepW-1:0]   step_t;
  typedef logic        [IdxW-1:0]    idx_t;

  localparam cnt_t  MaxCount   = cnt_t'(MaxSamples);
  localparam idx_t  CfgTherm   = 2'd0;
  localparam idx_t  CfgThin    = 2'd1;
  localparam fact_t ThermReset = 8'd20;
  localparam fact_t ThinReset  = 8'd2;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatTherm    = 2'd1;
  localparam logic [1:0] StatOverflow = 2'd2;

  localparam tau_t  TauHalf = tau_t'(32768);
  localparam tau_t  TauCap  = tau_t'(48'h8000_0000_0000);
  localparam step_t StepsTerm = step_t'(33);
  localparam step_t StepsCnt  = step_t'(13);
  localparam step_t StepsSe   = step_t'(64);

endpackage

FILE: design/autocorrelation_thinning_stats_unit.sv
// Top level: sample store and sequencer for autocorrelation time, cut, thinning and stats.
`timescale 1ns / 1ps

// Channel   | Ports                                            | Direction
// ----------+--------------------------------------------------+----------
// samples   | start_i, busy_o, sample_value_i, last_sample_i   | in
// results   | done_o, mean_value_o, standard_error_o,          | out
//           | auto_time_o, kept_count_o, status_code_o         |
// config    | cfg_we_i, cfg_idx_i, cfg_wdata_i                 | in
//
// Samples load one per cycle into a 4096-entry store while busy_o is low.
// The transaction flagged last starts the analysis; busy_o stays high for it.
// Analysis makes one or two autocorrelation estimates, each built from the
// two-port store reads, one lag pair per cycle, plus bit-serial multiply and
// divide steps per lag, and ends with a final square root.
// Reset clears the sample count and overflow flag and loads the default factors;
// the store has no reset.
// done_o pulses for one cycle with the result; the receiver cannot stall it.

module autocorrelation_thinning_stats_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [31:0]            sample_value_i,
  input  logic                          last_sample_i,
  input  logic                          cfg_we_i,
  input  logic [acts_pkg::IdxW-1:0]     cfg_idx_i,
  input  logic [acts_pkg::FactW-1:0]    cfg_wdata_i,
  output logic                          done_o,
  output logic signed [31:0]            mean_value_o,
  output logic [31:0]                   standard_error_o,
  output logic [31:0]                   auto_time_o,
  output logic [12:0]                   kept_count_o,
  output logic [1:0]                    status_code_o
);

  typedef enum logic [5:0] {
    S_IDLE, S_TAU_BEGIN, S_TAU_D0, S_TAU_LAG, S_TAU_DL, S_TAU_NUM, S_TAU_DEN,
    S_TAU_TERM, S_TAU_END, S_CUT_MUL, S_CUT_EVAL, S_THIN_MUL, S_THIN_EVAL,
    S_THIN_DIV, S_ST_BEGIN, S_ST_MEAN, S_ST_MEANR, S_ST_K2, S_ST_K3, S_ST_SQ,
    S_SQRT, S_OUT, S_LD_PASS, S_LD_M1, S_LD_M2, S_LD_SUB, S_MUL, S_DIV_CHK,
    S_DIV_STEP
  } state_e;

  // sample store, two read ports with registered data
  acts_pkg::smp_t mem [acts_pkg::MaxSamples];
  acts_pkg::smp_t rda_q, rdb_q;
  logic           mem_we;

  state_e state_q, ld_ret_q, mul_ret_q, div_ret_q;

  acts_pkg::fact_t therm_q, thin_q;
  acts_pkg::cnt_t  count_q, count_nx, len_q, n_q, base_q, lag_q, m_q, kept_q, stride_q;
  logic            ovf_q, phase_q;
  logic [1:0]      status_q;

  // lag pass
  acts_pkg::cnt_t  addr_a_q, addr_b_q, step_q, cnt_q;
  logic            v1_q, v2_q;
  acts_pkg::prod_t xprod_q;
  acts_pkg::smp_t  xa_q, xb_q;
  acts_pkg::pa_t   pa_q;
  acts_pkg::sum_t  pb_q, pc_q;
  acts_pkg::wide_t t1_q, d_q, d0_q;

  // shared multiplier
  acts_pkg::uwide_t mul_a_q, macc_q;
  logic [acts_pkg::SumW-1:0] mul_b_q;
  logic             mneg_q;
  acts_pkg::wide_t  prod_q;

  // shared divider
  acts_pkg::dwide_t rem_q, dsh_q;
  acts_pkg::quo_t   quo_q;
  acts_pkg::step_t  dcnt_q;
  logic             dovf_q;

  // square root
  acts_pkg::quo_t   sq_v_q, sq_r_q, sq_bit_q;

  acts_pkg::tau_t   acc_q, tau_q;
  acts_pkg::uwide_t num_q;
  acts_pkg::fprod_t fprod_q;
  logic             mean_neg_q;
  logic [31:0]      mean_q, se_q;

  // call requests
  logic             ld_go, mul_go, div_go;
  acts_pkg::cnt_t   ld_base, ld_lag, ld_step, ld_m;
  state_e           ld_ret, mul_ret, div_ret;
  acts_pkg::wide_t  mul_a_in;
  acts_pkg::sum_t   mul_b_in;
  acts_pkg::uwide_t div_num, div_den;
  acts_pkg::step_t  div_steps;

  // datapath helpers
  logic [acts_pkg::FprodW:0]   fround;
  logic [acts_pkg::FprodW-16:0] fq;
  logic [acts_pkg::TauW:0]     acc_sum;
  logic [31:0]                 term;
  logic                        d_pos;
  logic [acts_pkg::SumW-1:0]   pb_mag;
  logic [31:0]                 mean_mag;
  acts_pkg::quo_t              sq_try;

  assign busy_o   = (state_q != S_IDLE);
  assign mem_we   = (state_q == S_IDLE) && start_i && (count_q < acts_pkg::MaxCount);
  assign count_nx = mem_we ? count_q + 1'b1 : count_q;

  assign fround  = {1'b0, fprod_q} + (acts_pkg::FprodW + 1)'(acts_pkg::TauHalf);
  assign fq      = fround[acts_pkg::FprodW:16];
  assign d_pos   = !d_q[acts_pkg::WideW-1] && (d_q != '0);
  assign term    = (dovf_q || (quo_q[63:32] != '0)) ? 32'hFFFF_FFFF : quo_q[31:0];
  assign acc_sum = {1'b0, acc_q} + (acts_pkg::TauW + 1)'(term);
  assign pb_mag  = pb_q[acts_pkg::SumW-1] ? -pb_q : pb_q;
  assign mean_mag = (dovf_q || (quo_q > 64'h8000_0000)) ? 32'h8000_0000 : quo_q[31:0];
  assign sq_try  = sq_r_q + sq_bit_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[acts_pkg::AddrW-1:0]] <= sample_value_i;
    end
    rda_q <= mem[addr_a_q[acts_pkg::AddrW-1:0]];
    rdb_q <= mem[addr_b_q[acts_pkg::AddrW-1:0]];
  end

  // decide which unit a state hands work to
  always_comb begin
    ld_go = 1'b0; ld_base = '0; ld_lag = '0; ld_step = '0; ld_m = '0; ld_ret = S_IDLE;
    mul_go = 1'b0; mul_a_in = '0; mul_b_in = '0; mul_ret = S_IDLE;
    div_go = 1'b0; div_num = '0; div_den = '0; div_steps = '0; div_ret = S_IDLE;
    unique case (state_q)
      S_TAU_BEGIN: begin
        ld_go = 1'b1; ld_base = base_q; ld_step = acts_pkg::cnt_t'(1);
        ld_m = n_q; ld_ret = S_TAU_D0;
      end
      S_TAU_LAG: begin
        if (lag_q < n_q) begin
          ld_go = 1'b1; ld_base = base_q; ld_lag = lag_q;
          ld_step = acts_pkg::cnt_t'(1); ld_m = n_q - lag_q; ld_ret = S_TAU_DL;
        end
      end
      S_ST_BEGIN: begin
        if (kept_q != '0) begin
          ld_go = 1'b1; ld_base = base_q; ld_step = stride_q;
          ld_m = kept_q; ld_ret = S_ST_MEAN;
        end
      end
      S_LD_M1: begin
        mul_go = 1'b1; mul_a_in = acts_pkg::wide_t'(pa_q);
        mul_b_in = acts_pkg::sum_t'(m_q); mul_ret = S_LD_M2;
      end
      S_LD_M2: begin
        mul_go = 1'b1; mul_a_in = acts_pkg::wide_t'(pb_q);
        mul_b_in = pc_q; mul_ret = S_LD_SUB;
      end
      S_TAU_DL: begin
        if (d_pos) begin
          mul_go = 1'b1; mul_a_in = d_q; mul_b_in = acts_pkg::sum_t'(n_q);
          mul_ret = S_TAU_NUM;
        end
      end
      S_TAU_NUM: begin
        mul_go = 1'b1; mul_a_in = d0_q; mul_b_in = acts_pkg::sum_t'(m_q);
        mul_ret = S_TAU_DEN;
      end
      S_ST_MEANR: begin
        mul_go = 1'b1; mul_a_in = acts_pkg::wide_t'(kept_q);
        mul_b_in = acts_pkg::sum_t'(kept_q); mul_ret = S_ST_K2;
      end
      S_ST_K2: begin
        mul_go = 1'b1; mul_a_in = prod_q; mul_b_in = acts_pkg::sum_t'(kept_q);
        mul_ret = S_ST_K3;
      end
      S_TAU_DEN: begin
        div_go = 1'b1; div_num = num_q; div_den = prod_q;
        div_steps = acts_pkg::StepsTerm; div_ret = S_TAU_TERM;
      end
      S_THIN_EVAL: begin
        if ((fq > (acts_pkg::FprodW - 15)'(1)) && (fq <= (acts_pkg::FprodW - 15)'(n_q))) begin
          div_go = 1'b1; div_num = acts_pkg::uwide_t'(n_q);
          div_den = acts_pkg::uwide_t'(fq[acts_pkg::CntW-1:0]);
          div_steps = acts_pkg::StepsCnt; div_ret = S_THIN_DIV;
        end
      end
      S_ST_MEAN: begin
        div_go = 1'b1; div_num = acts_pkg::uwide_t'(pb_mag);
        div_den = acts_pkg::uwide_t'(kept_q); div_steps = acts_pkg::StepsTerm;
        div_ret = S_ST_MEANR;
      end
      S_ST_K3: begin
        if (!d_q[acts_pkg::WideW-1]) begin
          div_go = 1'b1; div_num = d_q; div_den = prod_q;
          div_steps = acts_pkg::StepsSe; div_ret = S_ST_SQ;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ld_ret_q <= S_IDLE; mul_ret_q <= S_IDLE; div_ret_q <= S_IDLE;
      therm_q <= acts_pkg::ThermReset; thin_q <= acts_pkg::ThinReset;
      count_q <= '0; ovf_q <= 1'b0; phase_q <= 1'b0; status_q <= acts_pkg::StatOk;
      len_q <= '0; n_q <= '0; base_q <= '0; lag_q <= '0; m_q <= '0;
      kept_q <= '0; stride_q <= '0;
      addr_a_q <= '0; addr_b_q <= '0; step_q <= '0; cnt_q <= '0;
      v1_q <= 1'b0; v2_q <= 1'b0; xprod_q <= '0; xa_q <= '0; xb_q <= '0;
      pa_q <= '0; pb_q <= '0; pc_q <= '0; t1_q <= '0; d_q <= '0; d0_q <= '0;
      mul_a_q <= '0; macc_q <= '0; mul_b_q <= '0; mneg_q <= 1'b0; prod_q <= '0;
      rem_q <= '0; dsh_q <= '0; quo_q <= '0; dcnt_q <= '0; dovf_q <= 1'b0;
      sq_v_q <= '0; sq_r_q <= '0; sq_bit_q <= '0;
      acc_q <= '0; tau_q <= '0; num_q <= '0; fprod_q <= '0;
      mean_neg_q <= 1'b0; mean_q <= '0; se_q <= '0;
      done_o <= 1'b0; mean_value_o <= '0; standard_error_o <= '0;
      auto_time_o <= '0; kept_count_o <= '0; status_code_o <= acts_pkg::StatOk;
    end else begin
      done_o <= 1'b0;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          acts_pkg::CfgTherm: therm_q <= cfg_wdata_i;
          acts_pkg::CfgThin:  thin_q  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            count_q <= count_nx;
            if (!mem_we) begin
              ovf_q <= 1'b1;
            end
            if (last_sample_i) begin
              len_q <= count_nx; n_q <= count_nx; base_q <= '0;
              phase_q <= 1'b0; status_q <= acts_pkg::StatOk;
              stride_q <= acts_pkg::cnt_t'(1);
              state_q <= S_TAU_BEGIN;
            end
          end
        end

        // ---- autocorrelation time over n samples from base ----
        S_TAU_BEGIN: begin
        end
        S_TAU_D0: begin
          d0_q <= d_q; acc_q <= '0; lag_q <= acts_pkg::cnt_t'(1);
          if (!d_pos) begin
            tau_q <= acts_pkg::TauHalf; state_q <= S_TAU_END;
          end else begin
            state_q <= S_TAU_LAG;
          end
        end
        S_TAU_LAG: begin
          if (lag_q >= n_q) begin
            tau_q <= acts_pkg::TauHalf + acc_q; state_q <= S_TAU_END;
          end
        end
        S_TAU_DL: begin
          if (!d_pos) begin
            tau_q <= acts_pkg::TauHalf + acc_q; state_q <= S_TAU_END;
          end
        end
        S_TAU_NUM: num_q <= acts_pkg::uwide_t'(prod_q) << 16;
        S_TAU_DEN: begin
        end
        S_TAU_TERM: begin
          // clamp the running sum at the cap
          acc_q   <= (acc_sum > (acts_pkg::TauW + 1)'(acts_pkg::TauCap)) ? acts_pkg::TauCap
                                                                           : acc_sum[acts_pkg::TauW-1:0];
          lag_q   <= lag_q + 1'b1;
          state_q <= S_TAU_LAG;
        end
        S_TAU_END: state_q <= phase_q ? S_THIN_MUL : S_CUT_MUL;

        // ---- thermalisation cut ----
        S_CUT_MUL: begin
          fprod_q <= acts_pkg::fprod_t'(therm_q) * acts_pkg::fprod_t'(tau_q);
          state_q <= S_CUT_EVAL;
        end
        S_CUT_EVAL: begin
          if (fq >= (acts_pkg::FprodW - 15)'(len_q)) begin
            status_q <= acts_pkg::StatTherm; kept_q <= len_q;
            base_q <= '0; stride_q <= acts_pkg::cnt_t'(1);
            state_q <= S_ST_BEGIN;
          end else begin
            base_q <= fq[acts_pkg::CntW-1:0];
            n_q    <= len_q - fq[acts_pkg::CntW-1:0];
            phase_q <= 1'b1;
            state_q <= S_TAU_BEGIN;
          end
        end

        // ---- thinning stride ----
        S_THIN_MUL: begin
          fprod_q <= acts_pkg::fprod_t'(thin_q) * acts_pkg::fprod_t'(tau_q);
          state_q <= S_THIN_EVAL;
        end
        S_THIN_EVAL: begin
          if (fq <= (acts_pkg::FprodW - 15)'(1)) begin
            kept_q <= n_q; stride_q <= acts_pkg::cnt_t'(1); state_q <= S_ST_BEGIN;
          end else if (fq > (acts_pkg::FprodW - 15)'(n_q)) begin
            kept_q <= '0; state_q <= S_ST_BEGIN;
          end else begin
            stride_q <= fq[acts_pkg::CntW-1:0];
          end
        end
        S_THIN_DIV: begin
          kept_q <= quo_q[acts_pkg::CntW-1:0]; state_q <= S_ST_BEGIN;
        end

        // ---- statistics of kept samples ----
        S_ST_BEGIN: begin
          if (kept_q == '0) begin
            mean_q <= '0; se_q <= '0; state_q <= S_OUT;
          end
        end
        S_ST_MEAN: mean_neg_q <= pb_q[acts_pkg::SumW-1];
        S_ST_MEANR: begin
          if (mean_neg_q) begin
            mean_q <= ~mean_mag + 1'b1;
          end else begin
            mean_q <= (dovf_q || (quo_q > 64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo_q[31:0];
          end
        end
        S_ST_K2: begin
        end
        S_ST_K3: begin
          if (d_q[acts_pkg::WideW-1]) begin
            se_q <= '0; state_q <= S_OUT;
          end
        end
        S_ST_SQ: begin
          if (dovf_q) begin
            se_q <= 32'hFFFF_FFFF; state_q <= S_OUT;
          end else begin
            sq_v_q <= quo_q; sq_r_q <= '0;
            sq_bit_q <= acts_pkg::quo_t'(1) << 62;
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_bit_q == '0) begin
            se_q <= sq_r_q[31:0]; state_q <= S_OUT;
          end else begin
            if (sq_v_q >= sq_try) begin
              sq_v_q <= sq_v_q - sq_try;
              sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
            end else begin
              sq_r_q <= sq_r_q >> 1;
            end
            sq_bit_q <= sq_bit_q >> 2;
          end
        end

        S_OUT: begin
          done_o           <= 1'b1;
          mean_value_o     <= mean_q;
          standard_error_o <= se_q;
          auto_time_o      <= (tau_q > acts_pkg::tau_t'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                         : tau_q[31:0];
          kept_count_o     <= kept_q;
          status_code_o    <= ovf_q ? acts_pkg::StatOverflow : status_q;
          count_q <= '0; ovf_q <= 1'b0;
          state_q <= S_IDLE;
        end

        // ---- lag pass: read pairs, multiply, accumulate ----
        S_LD_PASS: begin
          if (cnt_q != '0) begin
            addr_a_q <= addr_a_q + step_q;
            addr_b_q <= addr_b_q + step_q;
            cnt_q    <= cnt_q - 1'b1;
            v1_q     <= 1'b1;
          end else begin
            v1_q <= 1'b0;
          end
          v2_q <= v1_q;
          if (v1_q) begin
            xprod_q <= rda_q * rdb_q;
            xa_q <= rda_q; xb_q <= rdb_q;
          end
          if (v2_q) begin
            pa_q <= pa_q + acts_pkg::pa_t'(xprod_q);
            pb_q <= pb_q + acts_pkg::sum_t'(xa_q);
            pc_q <= pc_q + acts_pkg::sum_t'(xb_q);
          end
          if ((cnt_q == '0) && !v1_q && !v2_q) begin
            state_q <= S_LD_M1;
          end
        end
        S_LD_M1: t1_q <= '0;
        S_LD_M2: t1_q <= prod_q;
        S_LD_SUB: begin
          d_q <= t1_q - prod_q; state_q <= ld_ret_q;
        end

        // ---- shift-add multiply, stops when the multiplier runs out ----
        S_MUL: begin
          if (mul_b_q == '0) begin
            prod_q  <= mneg_q ? -acts_pkg::wide_t'(macc_q) : acts_pkg::wide_t'(macc_q);
            state_q <= mul_ret_q;
          end else begin
            if (mul_b_q[0]) begin
              macc_q <= macc_q + mul_a_q;
            end
            mul_a_q <= mul_a_q << 1;
            mul_b_q <= mul_b_q >> 1;
          end
        end

        // ---- restoring divide, one quotient bit a cycle ----
        S_DIV_CHK: begin
          dovf_q  <= (rem_q >= dsh_q);
          dsh_q   <= dsh_q >> 1;
          state_q <= S_DIV_STEP;
        end
        S_DIV_STEP: begin
          if (rem_q >= dsh_q) begin
            rem_q <= rem_q - dsh_q;
            quo_q <= {quo_q[acts_pkg::QuoW-2:0], 1'b1};
          end else begin
            quo_q <= {quo_q[acts_pkg::QuoW-2:0], 1'b0};
          end
          dsh_q  <= dsh_q >> 1;
          dcnt_q <= dcnt_q - 1'b1;
          if (dcnt_q == acts_pkg::step_t'(1)) begin
            state_q <= div_ret_q;
          end
        end

        default: state_q <= S_IDLE;
      endcase

      // launch requested unit work; overrides the transition above
      if (ld_go) begin
        addr_a_q <= ld_base; addr_b_q <= ld_base + ld_lag;
        step_q <= ld_step; cnt_q <= ld_m; m_q <= ld_m;
        v1_q <= 1'b0; v2_q <= 1'b0;
        pa_q <= '0; pb_q <= '0; pc_q <= '0;
        ld_ret_q <= ld_ret; state_q <= S_LD_PASS;
      end
      if (mul_go) begin
        mul_a_q <= mul_a_in[acts_pkg::WideW-1] ? acts_pkg::uwide_t'(-mul_a_in)
                                               : acts_pkg::uwide_t'(mul_a_in);
        mul_b_q <= mul_b_in[acts_pkg::SumW-1] ? -mul_b_in : mul_b_in;
        mneg_q  <= mul_a_in[acts_pkg::WideW-1] ^ mul_b_in[acts_pkg::SumW-1];
        macc_q  <= '0;
        mul_ret_q <= mul_ret; state_q <= S_MUL;
      end
      if (div_go) begin
        rem_q  <= acts_pkg::dwide_t'(div_num);
        dsh_q  <= acts_pkg::dwide_t'(div_den) << div_steps;
        dcnt_q <= div_steps; quo_q <= '0;
        div_ret_q <= div_ret; state_q <= S_DIV_CHK;
      end
    end
  end

endmodule
